// ----- hw/rtl/srcs_pkg.sv -----
// ----------------------------------------------------------------------------
// srcs_pkg
// Shared types and constants for the selective-repeat congestion sender.
// ----------------------------------------------------------------------------
package srcs_pkg;

	localparam int WINDOW_SLOTS_DEF = 32;
	localparam int CWND_MAX_DEF     = 1023;
	localparam int CWND_W           = 10;
	localparam int SEQ_W            = 32;
	localparam int SLOT_IDX_W       = 5;
	localparam int DUP_LIMIT        = 3;
	localparam int THRESH_RESET     = 16;
	localparam int QUEUE_DEPTH      = 2;

	typedef enum logic [1:0] {
		REQ_ACK     = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_POLL    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_RECOV = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SLOT_UNSENT = 2'd0,
		SLOT_OUT    = 2'd1,
		SLOT_ACKED  = 2'd2
	} slot_t;

	// back end sequencing
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SLIDE = 2'd1,
		ST_RES   = 2'd2
	} back_st_t;

	localparam logic [0:0] CFG_TOTAL  = 1'b0;
	localparam logic [0:0] CFG_THRESH = 1'b1;

	// classified item from front to back
	typedef struct packed {
		req_t                  req;
		logic [SEQ_W-1:0]      ack_seq;
		logic [SLOT_IDX_W-1:0] tslot;
	} cmd_t;

	typedef struct packed {
		logic                 send_valid;
		logic [SEQ_W-1:0]     send_seq;
		logic                 is_retransmit;
		logic [1:0]           phase;
		logic [CWND_W-1:0]    window_now;
		logic [CWND_W-1:0]    threshold_now;
		logic [SEQ_W-1:0]     base_now;
		logic                 all_done;
	} res_t;

endpackage

// ----- hw/rtl/srcs_front.sv -----
// ----------------------------------------------------------------------------
// srcs_front
// Accepts items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module srcs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  srcs_pkg::cmd_t    cmd_in,
	output logic              cmd_valid,
	input  logic              cmd_take,
	output srcs_pkg::cmd_t    cmd_out
);
	srcs_pkg::cmd_t q_q [srcs_pkg::QUEUE_DEPTH];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       do_push, do_pop;

	assign full      = (cnt_q == 2'(srcs_pkg::QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;
	assign cmd_out   = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= cmd_in;
	end
endmodule

// ----- hw/rtl/srcs_back.sv -----
// ----------------------------------------------------------------------------
// srcs_back
// Runs the window and congestion update for one item, then for an ACK of the
// base slides the base one slot a cycle. Holds the result until it is popped.
// ----------------------------------------------------------------------------
module srcs_back #(
	parameter int WINDOW_SLOTS = srcs_pkg::WINDOW_SLOTS_DEF,
	parameter int CWND_MAX     = srcs_pkg::CWND_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [srcs_pkg::SEQ_W-1:0]    cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_take,
	input  srcs_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_take,
	output srcs_pkg::res_t                res
);
	localparam int OFF_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CW    = srcs_pkg::CWND_W;
	localparam int SW    = srcs_pkg::SEQ_W;

	srcs_pkg::back_st_t st_q, st_d;

	logic [SW-1:0] total_q, base_q, next_q;
	logic [CW-1:0] cwnd_q, thr_q, avoid_q;
	logic [1:0]    dup_q;
	srcs_pkg::phase_t ph_q;
	srcs_pkg::slot_t  slot_q [WINDOW_SLOTS];
	logic           send_q, retx_q;
	logic [SW-1:0]  seq_q;
	logic           rvalid_q;

	logic done;
	logic [SW-1:0] off;
	logic [CW-1:0] eff, halv;
	logic inwin, inslots;
	logic [CW:0] cw_inc, thr3;
	logic [CW-1:0] cw_sat, thr3_sat;
	logic [CW-1:0] thr_cfg;
	logic [CW-1:0] av_inc, cw_mid, halv_mid;

	assign done    = (base_q >= total_q);
	assign off     = cmd.ack_seq - base_q;
	assign eff     = (cwnd_q < CW'(WINDOW_SLOTS)) ? cwnd_q : CW'(WINDOW_SLOTS);
	assign halv    = ((cwnd_q >> 1) == '0) ? CW'(1) : (cwnd_q >> 1);
	assign inwin   = (cmd.ack_seq >= base_q) && (off < SW'(eff));
	assign inslots = (cmd.ack_seq >= base_q) && (off < SW'(WINDOW_SLOTS));
	assign cw_inc  = {1'b0, cwnd_q} + (CW+1)'(1);
	assign cw_sat  = (cw_inc > (CW+1)'(CWND_MAX)) ? CW'(CWND_MAX) : cw_inc[CW-1:0];
	assign av_inc  = avoid_q + CW'(1);
	// window after the phase growth of an ACK; fast retransmit halves this one
	assign cw_mid  = (ph_q == srcs_pkg::PH_SLOW) ?
		((cwnd_q <= thr_q) ? cw_sat : cwnd_q) :
		((av_inc >= cwnd_q) ? cw_sat : cwnd_q);
	assign halv_mid = ((cw_mid >> 1) == '0) ? CW'(1) : (cw_mid >> 1);
	assign thr3    = {1'b0, halv_mid} + (CW+1)'(srcs_pkg::DUP_LIMIT);
	assign thr3_sat = (thr3 > (CW+1)'(CWND_MAX)) ? CW'(CWND_MAX) : thr3[CW-1:0];
	assign thr_cfg = (cfg_data[CW-1:0] == '0) ? CW'(1) : cfg_data[CW-1:0];

	assign cmd_take  = (st_q == srcs_pkg::ST_IDLE) && cmd_valid && !rvalid_q;
	assign res_valid = rvalid_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			srcs_pkg::ST_IDLE: if (cmd_take) begin
				st_d = (cmd.req == srcs_pkg::REQ_ACK && !done && inslots &&
					cmd.ack_seq == base_q) ? srcs_pkg::ST_SLIDE : srcs_pkg::ST_RES;
			end
			srcs_pkg::ST_SLIDE: if (slot_q[0] != srcs_pkg::SLOT_ACKED) st_d = srcs_pkg::ST_RES;
			srcs_pkg::ST_RES:   st_d = srcs_pkg::ST_IDLE;
			default:  st_d = srcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= srcs_pkg::ST_IDLE;
			total_q  <= '0;
			thr_q    <= CW'(srcs_pkg::THRESH_RESET);
			cwnd_q   <= CW'(1);
			avoid_q  <= '0;
			dup_q    <= '0;
			ph_q     <= srcs_pkg::PH_SLOW;
			base_q   <= '0;
			next_q   <= '0;
			rvalid_q <= 1'b0;
			send_q   <= 1'b0;
			retx_q   <= 1'b0;
			seq_q    <= '0;
			for (int i = 0; i < WINDOW_SLOTS; i++) slot_q[i] <= srcs_pkg::SLOT_UNSENT;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_idx == srcs_pkg::CFG_TOTAL) total_q <= cfg_data;
				else begin
					thr_q <= thr_cfg;
				end
			end
			if (res_take && rvalid_q) rvalid_q <= 1'b0;
			if (st_q == srcs_pkg::ST_RES) rvalid_q <= 1'b1;
			if (cmd_take) begin
				send_q <= 1'b0;
				retx_q <= 1'b0;
				seq_q  <= '0;
				if (!done) begin
					unique case (cmd.req)
						srcs_pkg::REQ_ACK: begin
							if (inwin) begin
								logic [1:0] dn;
								dn = (cmd.ack_seq == base_q) ? 2'd0 : dup_q + 2'd1;
								if (ph_q == srcs_pkg::PH_RECOV) begin
									if (cmd.ack_seq == base_q) begin
										cwnd_q <= thr_q;
										dup_q  <= '0;
										ph_q   <= srcs_pkg::PH_AVOID;
									end else cwnd_q <= cw_sat;
								end else begin
									if (ph_q == srcs_pkg::PH_SLOW) begin
										if (cwnd_q <= thr_q) cwnd_q <= cw_sat;
										else ph_q <= srcs_pkg::PH_AVOID;
									end else begin
										if (av_inc >= cwnd_q) begin
											cwnd_q  <= cw_sat;
											avoid_q <= '0;
										end else avoid_q <= av_inc;
									end
									if (dn == 2'(srcs_pkg::DUP_LIMIT)) begin
										thr_q  <= halv_mid;
										cwnd_q <= thr3_sat;
										ph_q   <= srcs_pkg::PH_RECOV;
										dup_q  <= '0;
										send_q <= 1'b1;
										retx_q <= 1'b1;
										seq_q  <= base_q;
									end else dup_q <= dn;
								end
							end
							if (inslots && slot_q[off[OFF_W-1:0]] == srcs_pkg::SLOT_OUT)
								slot_q[off[OFF_W-1:0]] <= srcs_pkg::SLOT_ACKED;
						end
						srcs_pkg::REQ_TIMEOUT: begin
							if (32'(cmd.tslot) < WINDOW_SLOTS &&
								slot_q[OFF_W'(cmd.tslot)] == srcs_pkg::SLOT_OUT) begin
								send_q <= 1'b1;
								retx_q <= 1'b1;
								seq_q  <= base_q + SW'(cmd.tslot);
								thr_q  <= halv;
								cwnd_q <= CW'(1);
								ph_q   <= srcs_pkg::PH_SLOW;
							end
						end
						srcs_pkg::REQ_POLL: begin
							if ({1'b0, next_q} < {1'b0, base_q} + (SW+1)'(eff) &&
								next_q < total_q) begin
								if ((next_q - base_q) < SW'(WINDOW_SLOTS))
									slot_q[OFF_W'(next_q - base_q)] <= srcs_pkg::SLOT_OUT;
								send_q <= 1'b1;
								seq_q  <= next_q;
								next_q <= next_q + SW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			// slide one acknowledged slot per cycle
			if (st_q == srcs_pkg::ST_SLIDE && slot_q[0] == srcs_pkg::SLOT_ACKED) begin
				for (int i = 0; i < WINDOW_SLOTS - 1; i++) slot_q[i] <= slot_q[i+1];
				slot_q[WINDOW_SLOTS-1] <= srcs_pkg::SLOT_UNSENT;
				base_q <= base_q + SW'(1);
			end
		end
	end

	always_comb begin
		res.send_valid    = send_q;
		res.send_seq      = seq_q;
		res.is_retransmit = retx_q;
		res.phase         = ph_q;
		res.window_now    = cwnd_q;
		res.threshold_now = thr_q;
		res.base_now      = base_q;
		res.all_done      = done;
	end
endmodule

// ----- hw/rtl/selective_repeat_congestion_sender.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_congestion_sender
// Selective-repeat sender window with Reno-style congestion control.
// ----------------------------------------------------------------------------
// Items (ACK, slot timeout, send poll) enter through push/full into a
// two-entry queue. The back end takes one item at a time: it runs the
// update, then for an ACK of the window base it slides the base over each
// acknowledged slot in turn until it finds the first open slot, then it
// posts the result. An item that enters an idle block is queued, taken for
// the update and then posted, in that order. An ACK of the base slides the
// base over at most WINDOW_SLOTS slots. One result per item is shown on the
// result ports while empty is low and leaves on pop. While a result is
// unpopped the back end takes no new item; the queue still accepts up to
// two more, then full rises.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 total_packets,
// index 1 initial_threshold (0 loads as 1; also reloads the threshold).
// Reset (arst_n low) empties the queue, clears all slots and restores the
// congestion state: slow start, window 1, threshold 16.
// ----------------------------------------------------------------------------
module selective_repeat_congestion_sender #(
	parameter int WINDOW_SLOTS = srcs_pkg::WINDOW_SLOTS_DEF,
	parameter int CWND_MAX     = srcs_pkg::CWND_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] ack_seq,
	input  logic [4:0]  timed_out_slot,
	output logic        empty,
	input  logic        pop,
	output logic        send_valid,
	output logic [31:0] send_seq,
	output logic        is_retransmit,
	output logic [1:0]  phase,
	output logic [9:0]  window_now,
	output logic [9:0]  threshold_now,
	output logic [31:0] base_now,
	output logic        all_done
);
	srcs_pkg::cmd_t cin, cq;
	srcs_pkg::res_t res;
	logic cvalid, ctake, rvalid;

	assign cin.req     = srcs_pkg::req_t'(req_type);
	assign cin.ack_seq = ack_seq;
	assign cin.tslot   = timed_out_slot;

	srcs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cin),
		.cmd_valid(cvalid), .cmd_take(ctake), .cmd_out(cq)
	);

	srcs_back #(.WINDOW_SLOTS(WINDOW_SLOTS), .CWND_MAX(CWND_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data), .cmd_valid(cvalid), .cmd_take(ctake), .cmd(cq),
		.res_valid(rvalid), .res_take(pop), .res(res)
	);

	assign empty         = !rvalid;
	assign send_valid    = res.send_valid;
	assign send_seq      = res.send_seq;
	assign is_retransmit = res.is_retransmit;
	assign phase         = res.phase;
	assign window_now    = res.window_now;
	assign threshold_now = res.threshold_now;
	assign base_now      = res.base_now;
	assign all_done      = res.all_done;
endmodule
